// ----- hdl/kufe_pkg.sv -----
package kufe_pkg;

    localparam int VID_W    = 8;
    localparam int WEIGHT_W = 16;
    localparam int CNT_W    = 8;
    localparam int RANK_W   = 4;

    localparam logic [RANK_W-1:0] RANK_MAX     = 4'd15;
    localparam logic [CNT_W-1:0]  TARGET_RESET = 8'd8;

    typedef struct packed {
        logic                start_graph;
        logic [VID_W-1:0]    edge_src;
        logic [VID_W-1:0]    edge_dst;
        logic [WEIGHT_W-1:0] edge_weight;
    } t_edge_in;

    typedef struct packed {
        logic                accepted;
        logic                tree_complete;
        logic [CNT_W-1:0]    accepted_count;
        logic [VID_W-1:0]    out_src;
        logic [VID_W-1:0]    out_dst;
        logic [WEIGHT_W-1:0] out_weight;
    } t_edge_out;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_FIND_RD,
        S_FIND_CHK,
        S_CMP_TEST,
        S_CMP_WR,
        S_UNION_RANK,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clr_init;
        logic clr_wr;
        logic cur_from_edge;
        logic sel_dst;
        logic cur_from_data;
        logic rd_en;
        logic root_latch;
        logic cmp_wr;
        logic side_to_dst;
        logic union_wr;
        logic union_rank_wr;
        logic publish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_start;
        logic clr_last;
        logic eligible;
        logic at_root;
        logic cur_is_root;
        logic side;
        logic roots_differ;
        logic ranks_equal;
        logic out_free;
    } t_stat;

endpackage

// ----- hdl/kruskal_union_find_edge_filter.sv -----
// Channel   Direction  Handshake           Payload
// in        input      i_in_valid/o_in_stall    t_edge_in (edge and start flag)
// out       output     o_out_valid/i_out_stall  t_edge_out (decision and echo)
// cfg       input      i_cfg_valid/o_cfg_ready  tree_edge_target, 8 bits
//
// After reset, and before an item with start_graph set is handled, a clearing pass resets
// all MAX_VERTICES parent/rank entries. An edge that is looked up takes longer for each
// parent link walked in each find and each link rewritten by path compression, and more when a
// union raises a rank; the memory serves one access at a time. A rejected edge (target
// reached or vertex out of range) skips the finds. The next item is taken while one result
// waits in the output register; a second result stalls the input until the first transfers.
module kruskal_union_find_edge_filter
    import kufe_pkg::*;
#(
    parameter int MAX_VERTICES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_edge_in         i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_edge_out        o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    kufe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    kufe_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

// ----- hdl/kufe_ctrl.sv -----
module kufe_ctrl
    import kufe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_resume, n_resume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_resume <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_resume <= n_resume;
        end
    end

    // Next state.
    always_comb begin
        n_state  = r_state;
        n_resume = r_resume;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state  = r_resume ? S_CHECK : S_IDLE;
                    n_resume = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.in_start) begin
                        n_state  = S_CLEAR;
                        n_resume = 1'b1;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_state = i_stat.eligible ? S_FIND_RD : S_FINISH;
            end
            S_FIND_RD: begin
                n_state = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                n_state = i_stat.at_root ? S_CMP_TEST : S_FIND_RD;
            end
            S_CMP_TEST: begin
                priority if (!i_stat.cur_is_root) begin
                    n_state = S_CMP_WR;
                end else if (!i_stat.side) begin
                    n_state = S_FIND_RD;
                end else if (i_stat.roots_differ && i_stat.ranks_equal) begin
                    n_state = S_UNION_RANK;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_CMP_WR: begin
                n_state = S_CMP_TEST;
            end
            S_UNION_RANK: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.clr_init = i_stat.in_start;
                end
            end
            S_CHECK: begin
                o_cmd.cur_from_edge = i_stat.eligible;
            end
            S_FIND_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            S_FIND_CHK: begin
                if (i_stat.at_root) begin
                    // Found the root: go back to the endpoint to compress its path.
                    o_cmd.root_latch    = 1'b1;
                    o_cmd.cur_from_edge = 1'b1;
                    o_cmd.sel_dst       = i_stat.side;
                end else begin
                    o_cmd.cur_from_data = 1'b1;
                end
            end
            S_CMP_TEST: begin
                priority if (!i_stat.cur_is_root) begin
                    o_cmd.rd_en = 1'b1;
                end else if (!i_stat.side) begin
                    o_cmd.side_to_dst   = 1'b1;
                    o_cmd.cur_from_edge = 1'b1;
                    o_cmd.sel_dst       = 1'b1;
                end else begin
                    o_cmd.union_wr = i_stat.roots_differ;
                end
            end
            S_CMP_WR: begin
                o_cmd.cmp_wr = 1'b1;
            end
            S_UNION_RANK: begin
                o_cmd.union_rank_wr = 1'b1;
            end
            S_FINISH: begin
                o_cmd.publish = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_load_only_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_in_stall)
        else $error("item loaded while the input is stalled");

    a_start_goes_to_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_stat.in_start) |=> (r_state == S_CLEAR && r_resume))
        else $error("start flag did not trigger a clearing pass");

    a_single_mem_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> !(o_cmd.clr_wr || o_cmd.cmp_wr || o_cmd.union_wr
                          || o_cmd.union_rank_wr))
        else $error("memory read and write issued together");
`endif

endmodule

// ----- hdl/kufe_dp.sv -----
module kufe_dp
    import kufe_pkg::*;
#(
    parameter int MAX_VERTICES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_edge_in         i_in,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output t_edge_out        o_out,
    input  logic             i_cfg_valid,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  t_cmd             i_cmd,
    output t_stat            o_stat
);

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EW = RANK_W + VW;
    localparam logic [VW-1:0] LAST_V = VW'(MAX_VERTICES - 1);

    // Each entry holds {rank, parent}.
    logic [EW-1:0]     r_mem [MAX_VERTICES];
    logic [EW-1:0]     r_rd_data;

    t_edge_in          r_edge;
    logic [CNT_W-1:0]  r_target;
    logic [CNT_W-1:0]  r_count;
    logic [VW-1:0]     r_cur;
    logic [VW-1:0]     r_root_x, r_root_y;
    logic [RANK_W-1:0] r_rank_x, r_rank_y;
    logic              r_side;
    logic              r_take;
    logic [VW-1:0]     r_clr_idx;
    logic              r_out_valid;
    t_edge_out         r_out;

    logic [VW-1:0]     src_a, dst_a, end_a, root_s;
    logic [VW-1:0]     rd_parent;
    logic [RANK_W-1:0] rd_rank;
    logic [RANK_W-1:0] rank_inc;
    logic              src_ok, dst_ok;
    logic              mem_we;
    logic [VW-1:0]     mem_wa;
    logic [EW-1:0]     mem_wd;

    assign src_a     = VW'(r_edge.edge_src);
    assign dst_a     = VW'(r_edge.edge_dst);
    assign end_a     = i_cmd.sel_dst ? dst_a : src_a;
    assign root_s    = r_side ? r_root_y : r_root_x;
    assign rd_parent = r_rd_data[VW-1:0];
    assign rd_rank   = r_rd_data[EW-1:VW];
    assign rank_inc  = (r_rank_x < RANK_MAX) ? r_rank_x + 1'b1 : r_rank_x;
    assign src_ok    = 32'(r_edge.edge_src) < 32'(MAX_VERTICES);
    assign dst_ok    = 32'(r_edge.edge_dst) < 32'(MAX_VERTICES);

    always_comb begin
        mem_we = 1'b1;
        mem_wa = r_clr_idx;
        mem_wd = {{RANK_W{1'b0}}, r_clr_idx};
        priority if (i_cmd.clr_wr) begin
            mem_wa = r_clr_idx;
            mem_wd = {{RANK_W{1'b0}}, r_clr_idx};
        end else if (i_cmd.cmp_wr) begin
            mem_wa = r_cur;
            mem_wd = {rd_rank, root_s};
        end else if (i_cmd.union_wr) begin
            // The lower-ranked root hangs below the other; on a tie the source root wins.
            if (r_rank_x < r_rank_y) begin
                mem_wa = r_root_x;
                mem_wd = {r_rank_x, r_root_y};
            end else begin
                mem_wa = r_root_y;
                mem_wd = {r_rank_y, r_root_x};
            end
        end else if (i_cmd.union_rank_wr) begin
            mem_wa = r_root_x;
            mem_wd = {rank_inc, r_root_x};
        end else begin
            mem_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_cur];
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_edge <= i_in;
        end
        if (i_cmd.cur_from_edge) begin
            r_cur <= end_a;
        end else if (i_cmd.cur_from_data || i_cmd.cmp_wr) begin
            r_cur <= rd_parent;
        end
        if (i_cmd.root_latch) begin
            if (r_side) begin
                r_root_y <= r_cur;
                r_rank_y <= rd_rank;
            end else begin
                r_root_x <= r_cur;
                r_rank_x <= rd_rank;
            end
        end
        if (i_cmd.publish) begin
            r_out.accepted       <= r_take;
            r_out.tree_complete  <= (r_count >= r_target);
            r_out.accepted_count <= r_count;
            r_out.out_src        <= r_edge.edge_src;
            r_out.out_dst        <= r_edge.edge_dst;
            r_out.out_weight     <= r_edge.edge_weight;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= TARGET_RESET;
            r_count     <= '0;
            r_side      <= 1'b0;
            r_take      <= 1'b0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_target <= i_cfg_data;
            end
            if (i_cmd.clr_init) begin
                r_count <= '0;
            end else if (i_cmd.union_wr) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.load) begin
                r_side <= 1'b0;
            end else if (i_cmd.side_to_dst) begin
                r_side <= 1'b1;
            end
            if (i_cmd.load) begin
                r_take <= 1'b0;
            end else if (i_cmd.union_wr) begin
                r_take <= 1'b1;
            end
            if (i_cmd.clr_init) begin
                r_clr_idx <= '0;
            end else if (i_cmd.clr_wr) begin
                r_clr_idx <= (r_clr_idx == LAST_V) ? '0 : r_clr_idx + 1'b1;
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.in_start     = i_in.start_graph;
    assign o_stat.clr_last     = (r_clr_idx == LAST_V);
    assign o_stat.eligible     = src_ok && dst_ok && (r_count < r_target);
    assign o_stat.at_root      = (rd_parent == r_cur);
    assign o_stat.cur_is_root  = (r_cur == root_s);
    assign o_stat.side         = r_side;
    assign o_stat.roots_differ = (r_root_x != r_root_y);
    assign o_stat.ranks_equal  = (r_rank_x == r_rank_y);
    assign o_stat.out_free     = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_publish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |-> !(r_out_valid && i_out_stall))
        else $error("result overwritten while the output is stalled");

    a_take_below_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.union_wr |-> (r_count < r_target))
        else $error("union performed with the target already reached");

    a_union_after_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.union_wr |-> (r_side && r_root_x != r_root_y))
        else $error("union issued without two distinct roots");

    a_take_counts_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.union_wr && !i_cmd.clr_init) |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted count did not advance on a union");
`endif

endmodule
